// ----- rtl/npi_pkg.sv -----
`default_nettype none
package npi_pkg;
	localparam int unsigned SUM_W = 22;
	localparam int unsigned POS_W = 10;
	localparam int unsigned CNT_W = 11;
	localparam int unsigned PC_W  = 7;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	typedef enum logic [2:0] {
		MODE_ERR  = 3'd0,
		MODE_ROWS = 3'd1,
		MODE_COLS = 3'd2,
		MODE_RBLK = 3'd3,
		MODE_CBLK = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		REG_PULSE = 2'd0,
		REG_ROWS  = 2'd1,
		REG_COLS  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic start;
		logic setup;
	} npi_cmd_t;

	typedef struct packed {
		logic sqrt_done;
		logic setup_done;
	} npi_stat_t;
endpackage
`default_nettype wire

// ----- rtl/noncoherent_pulse_integrator_unit.sv -----
// Flow: a sample is taken only in the idle state; it is squared and summed, and its root
//   is found by the bit-serial square-root unit, one root bit per cycle, then written back.
//   No new sample is taken until that is done and any result beat has been accepted.
// Reset: asynchronous, active low; registers return to their reset values and a
//   layout setup runs before the first sample.
`default_nettype none
module noncoherent_pulse_integrator_unit #(
	parameter int unsigned MAX_PULSES  = 64,
	parameter int unsigned MAX_DIM     = 1024,
	parameter int unsigned ACC_DEPTH   = 4096,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [3:0]                    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_real,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_imag,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [21:0]                        mag_sum,
	output logic [9:0]                         out_row,
	output logic [9:0]                         out_col,
	output logic                               last_of_matrix,
	output logic                               status
);
	logic [npi_pkg::PC_W-1:0]  pulse_q;
	logic [npi_pkg::CNT_W-1:0] rows_q, cols_q;
	logic                      wr, cfg_wr;
	npi_pkg::npi_cmd_t         cmd;
	npi_pkg::npi_stat_t        stat;
	logic                      emit;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign cfg_wr = wr && (paddr[3:2] == npi_pkg::REG_PULSE || paddr[3:2] == npi_pkg::REG_ROWS
	                || paddr[3:2] == npi_pkg::REG_COLS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q <= npi_pkg::PC_W'(5);
			rows_q  <= npi_pkg::CNT_W'(5);
			cols_q  <= npi_pkg::CNT_W'(64);
		end else if (wr) begin
			case (paddr[3:2])
				npi_pkg::REG_PULSE: pulse_q <= pwdata[npi_pkg::PC_W-1:0];
				npi_pkg::REG_ROWS:  rows_q  <= pwdata[npi_pkg::CNT_W-1:0];
				npi_pkg::REG_COLS:  cols_q  <= pwdata[npi_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			npi_pkg::REG_PULSE: prdata = 32'(pulse_q);
			npi_pkg::REG_ROWS:  prdata = 32'(rows_q);
			npi_pkg::REG_COLS:  prdata = 32'(cols_q);
			default:            prdata = '0;
		endcase
	end

	npi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.emit      (emit),
		.cmd       (cmd),
		.stat      (stat)
	);

	npi_dp #(
		.MAX_PULSES  (MAX_PULSES),
		.MAX_DIM     (MAX_DIM),
		.ACC_DEPTH   (ACC_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr         (cfg_wr),
		.pulse_count    (pulse_q),
		.matrix_rows    (rows_q),
		.matrix_cols    (cols_q),
		.cmd            (cmd),
		.stat           (stat),
		.sample_real    (sample_real),
		.sample_imag    (sample_imag),
		.emit           (emit),
		.mag_sum        (mag_sum),
		.out_row        (out_row),
		.out_col        (out_col),
		.last_of_matrix (last_of_matrix),
		.status         (status)
	);
endmodule
`default_nettype wire

// ----- rtl/npi_ram.sv -----
`default_nettype none
module npi_ram #(
	parameter int unsigned WIDTH = 22,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/npi_ctrl.sv -----
`default_nettype none
module npi_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire logic                 emit,
	output npi_pkg::npi_cmd_t         cmd,
	input  wire npi_pkg::npi_stat_t   stat
);
	typedef enum logic [4:0] {
		ST_SETUP = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_CALC  = 5'b00100,
		ST_WRITE = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SETUP;
		end else if (cfg_wr) begin
			state_q <= ST_SETUP;
		end else begin
			case (state_q)
				ST_SETUP: if (stat.setup_done) state_q <= ST_IDLE;
				ST_IDLE:  if (in_valid) state_q <= ST_CALC;
				ST_CALC:  if (stat.sqrt_done) state_q <= ST_WRITE;
				ST_WRITE: state_q <= emit ? ST_OUT : ST_IDLE;
				ST_OUT:   if (out_ready) state_q <= ST_IDLE;
				default:  state_q <= ST_SETUP;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign cmd.start = (state_q == ST_IDLE) && in_valid;
	assign cmd.setup = (state_q == ST_SETUP);
endmodule
`default_nettype wire

// ----- rtl/npi_dp.sv -----
`default_nettype none
module npi_dp #(
	parameter int unsigned MAX_PULSES  = 64,
	parameter int unsigned MAX_DIM     = 1024,
	parameter int unsigned ACC_DEPTH   = 4096,
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr,
	input  wire logic [npi_pkg::PC_W-1:0]   pulse_count,
	input  wire logic [npi_pkg::CNT_W-1:0]  matrix_rows,
	input  wire logic [npi_pkg::CNT_W-1:0]  matrix_cols,
	input  wire npi_pkg::npi_cmd_t          cmd,
	output npi_pkg::npi_stat_t              stat,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_real,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_imag,
	output logic                            emit,
	output logic [npi_pkg::SUM_W-1:0]       mag_sum,
	output logic [npi_pkg::POS_W-1:0]       out_row,
	output logic [npi_pkg::POS_W-1:0]       out_col,
	output logic                            last_of_matrix,
	output logic                            status
);
	localparam int unsigned AW  = $clog2(ACC_DEPTH);
	localparam int unsigned DW  = $clog2(MAX_DIM + 1);
	localparam int unsigned SQW = 2 * SAMPLE_BITS;
	localparam int unsigned RW  = SAMPLE_BITS + 1;
	localparam int unsigned NIT = RW;
	localparam int unsigned IW  = $clog2(NIT + 1);
	localparam int unsigned NW  = 2 * DW + 2;
	localparam int unsigned SW  = npi_pkg::SUM_W;

	// effective dimensions
	logic [DW-1:0] rows_e, cols_e;
	always_comb begin
		if (matrix_rows == '0) rows_e = DW'(1);
		else if (32'(matrix_rows) > MAX_DIM) rows_e = DW'(MAX_DIM);
		else rows_e = DW'(matrix_rows);
		if (matrix_cols == '0) cols_e = DW'(1);
		else if (32'(matrix_cols) > MAX_DIM) cols_e = DW'(MAX_DIM);
		else cols_e = DW'(matrix_cols);
	end

	// setup: repeated subtraction finds rows/P, cols/P; one product for the need check
	typedef enum logic [6:0] {
		SU_INIT = 7'b0000001,
		SU_RDIV = 7'b0000010,
		SU_CDIV = 7'b0000100,
		SU_MUL  = 7'b0001000,
		SU_CHK  = 7'b0010000,
		SU_DONE = 7'b0100000,
		SU_WAIT = 7'b1000000
	} su_t;

	su_t              su_q;
	logic [DW-1:0]    rrem_q, rquo_q, crem_q, cquo_q;
	logic [NW-1:0]    need_q;
	npi_pkg::mode_t   mode_q;
	logic [DW-1:0]    p_e;
	logic             p_ok;

	assign p_e  = DW'(pulse_count);
	assign p_ok = (pulse_count != '0) && (32'(pulse_count) <= MAX_PULSES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			su_q   <= SU_INIT;
			mode_q <= npi_pkg::MODE_ERR;
		end else if (cfg_wr) begin
			su_q <= SU_INIT;
		end else begin
			case (su_q)
				SU_INIT: begin
					rrem_q <= rows_e;
					rquo_q <= '0;
					crem_q <= cols_e;
					cquo_q <= '0;
					su_q   <= p_ok ? SU_RDIV : SU_CHK;
					need_q <= '0;
					mode_q <= npi_pkg::MODE_ERR;
				end
				SU_RDIV: begin
					if (rrem_q >= p_e) begin
						rrem_q <= rrem_q - p_e;
						rquo_q <= rquo_q + DW'(1);
					end else begin
						su_q <= SU_CDIV;
					end
				end
				SU_CDIV: begin
					if (crem_q >= p_e) begin
						crem_q <= crem_q - p_e;
						cquo_q <= cquo_q + DW'(1);
					end else begin
						su_q <= SU_MUL;
					end
				end
				SU_MUL: begin
					su_q <= SU_CHK;
					if (rows_e == p_e) begin
						mode_q <= npi_pkg::MODE_ROWS;
						need_q <= NW'(cols_e);
					end else if (cols_e == p_e) begin
						mode_q <= npi_pkg::MODE_COLS;
						need_q <= NW'(1);
					end else if (rrem_q == '0) begin
						mode_q <= npi_pkg::MODE_RBLK;
						need_q <= NW'(rquo_q) * NW'(cols_e);
					end else if (crem_q == '0) begin
						mode_q <= npi_pkg::MODE_CBLK;
						need_q <= NW'(cquo_q);
					end
				end
				SU_CHK: begin
					if (need_q > NW'(ACC_DEPTH)) mode_q <= npi_pkg::MODE_ERR;
					su_q <= SU_DONE;
				end
				SU_DONE: su_q <= SU_WAIT;
				SU_WAIT: su_q <= SU_WAIT;
				default: su_q <= SU_INIT;
			endcase
		end
	end
	assign stat.setup_done = (su_q == SU_DONE);

	// position and layout counters
	logic [DW-1:0] r_q, c_q, pr_q, orow_q, pc_q, ocol_q;
	logic [NW-1:0] rbase_q;
	logic          last_w, cwrap, rwrap;
	assign cwrap  = (c_q + DW'(1) >= cols_e);
	assign rwrap  = (r_q + DW'(1) >= rows_e);
	assign last_w = cwrap && rwrap;

	logic [DW-1:0] pulse_w, orow_w, ocol_w;
	logic [NW-1:0] idx_w;
	always_comb begin
		pulse_w = '0; orow_w = '0; ocol_w = '0; idx_w = '0;
		case (mode_q)
			npi_pkg::MODE_ROWS: begin
				pulse_w = r_q; ocol_w = c_q; idx_w = NW'(c_q);
			end
			npi_pkg::MODE_COLS: begin
				pulse_w = c_q; orow_w = r_q;
			end
			npi_pkg::MODE_RBLK: begin
				pulse_w = pr_q; orow_w = orow_q; ocol_w = c_q;
				idx_w = rbase_q + NW'(c_q);
			end
			npi_pkg::MODE_CBLK: begin
				pulse_w = pc_q; orow_w = r_q; ocol_w = ocol_q; idx_w = NW'(ocol_q);
			end
			default: ;
		endcase
		if (idx_w >= NW'(ACC_DEPTH)) idx_w = '0;
	end

	// item registers
	logic [RW-1:0]  are_q, aim_q;
	logic [SQW+1:0] rad_q;
	logic [RW-1:0]  root_q;
	logic [SQW+1:0] rem_q;
	logic [IW-1:0]  it_q;
	logic           mul_q;
	logic [AW-1:0]  idx_s1;
	logic           first_s1, fin_s1, last_s1, err_s1;
	logic [DW-1:0]  orow_s1, ocol_s1;
	logic [SW-1:0]  acc_rd;
	logic [SW:0]    sum_w;
	logic [SW-1:0]  sum_sat;
	logic           wr_en, wr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0; c_q <= '0; pr_q <= '0; orow_q <= '0;
			pc_q <= '0; ocol_q <= '0; rbase_q <= '0;
		end else if (cmd.setup) begin
			r_q <= '0; c_q <= '0; pr_q <= '0; orow_q <= '0;
			pc_q <= '0; ocol_q <= '0; rbase_q <= '0;
		end else if (cmd.start) begin
			if (cwrap) begin
				c_q <= '0; pc_q <= '0; ocol_q <= '0;
				if (rwrap) begin
					r_q <= '0; pr_q <= '0; orow_q <= '0; rbase_q <= '0;
				end else begin
					r_q <= r_q + DW'(1);
					if (orow_q + DW'(1) >= rquo_q) begin
						orow_q <= '0; pr_q <= pr_q + DW'(1); rbase_q <= '0;
					end else begin
						orow_q  <= orow_q + DW'(1);
						rbase_q <= rbase_q + NW'(cols_e);
					end
				end
			end else begin
				c_q <= c_q + DW'(1);
				if (ocol_q + DW'(1) >= cquo_q) begin
					ocol_q <= '0; pc_q <= pc_q + DW'(1);
				end else begin
					ocol_q <= ocol_q + DW'(1);
				end
			end
		end
	end

	// magnitude: square and add, then bit-serial restoring root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q  <= '0;
			mul_q <= 1'b0;
		end else if (cmd.start) begin
			mul_q <= 1'b1;
			it_q  <= '0;
		end else if (mul_q) begin
			mul_q <= 1'b0;
			it_q  <= IW'(NIT);
		end else if (it_q != '0) begin
			it_q <= it_q - IW'(1);
		end
	end

	logic [SQW+1:0] trial_w;
	logic [SQW+1:0] rem_sh;
	assign rem_sh  = {rem_q[SQW-1:0], rad_q[SQW+1:SQW]};
	assign trial_w = (SQW+2)'({root_q, 2'b01});

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			are_q    <= sample_real[SAMPLE_BITS-1] ? RW'(-$signed({sample_real[SAMPLE_BITS-1],
			            sample_real})) : RW'({1'b0, sample_real});
			aim_q    <= sample_imag[SAMPLE_BITS-1] ? RW'(-$signed({sample_imag[SAMPLE_BITS-1],
			            sample_imag})) : RW'({1'b0, sample_imag});
			idx_s1   <= AW'(idx_w);
			first_s1 <= (pulse_w == '0);
			fin_s1   <= (pulse_w + DW'(1) == p_e);
			last_s1  <= last_w;
			err_s1   <= (mode_q == npi_pkg::MODE_ERR);
			orow_s1  <= orow_w;
			ocol_s1  <= ocol_w;
		end else if (mul_q) begin
			rad_q  <= (SQW+2)'(are_q * are_q) + (SQW+2)'(aim_q * aim_q);
			root_q <= '0;
			rem_q  <= '0;
		end else if (it_q != '0) begin
			rad_q <= {rad_q[SQW-1:0], 2'b00};
			if (rem_sh >= trial_w) begin
				rem_q  <= rem_sh - trial_w;
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end
	assign stat.sqrt_done = (it_q == IW'(1));

	npi_ram #(.WIDTH(SW), .DEPTH(ACC_DEPTH)) u_acc (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_s1),
		.wdata (sum_sat),
		.raddr (idx_s1),
		.rdata (acc_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wr_q <= 1'b0;
		else wr_q <= stat.sqrt_done;
	end
	assign wr_en = wr_q && !err_s1;

	assign sum_w   = first_s1 ? (SW+1)'(root_q) : (SW+1)'(acc_rd) + (SW+1)'(root_q);
	assign sum_sat = sum_w[SW] ? npi_pkg::SUM_MAX : sum_w[SW-1:0];
	assign emit    = wr_q && (err_s1 ? last_s1 : fin_s1);

	always_ff @(posedge clk) begin
		if (wr_q) begin
			mag_sum        <= err_s1 ? '0 : sum_sat;
			out_row        <= err_s1 ? '0 : npi_pkg::POS_W'(orow_s1);
			out_col        <= err_s1 ? '0 : npi_pkg::POS_W'(ocol_s1);
			last_of_matrix <= last_s1;
			status         <= err_s1;
		end
	end
endmodule
`default_nettype wire

// ----- bench/tb_noncoherent_pulse_integrator_unit.sv -----
`timescale 1ns / 100ps
module tb_noncoherent_pulse_integrator_unit;
	typedef struct packed {
		logic [21:0] sum;
		logic [9:0]  row;
		logic [9:0]  col;
		logic        last;
		logic        status;
	} sum_beat_t;

	typedef struct packed {
		logic signed [15:0] re;
		logic signed [15:0] im;
	} sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] sample_real = '0, sample_imag = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [21:0] mag_sum;
	logic [9:0] out_row, out_col;
	logic last_of_matrix, status;

	noncoherent_pulse_integrator_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.sample_real(sample_real), .sample_imag(sample_imag),
		.out_valid(out_valid), .out_ready(out_ready),
		.mag_sum(mag_sum), .out_row(out_row), .out_col(out_col),
		.last_of_matrix(last_of_matrix), .status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sample_t   pending_samples[$];
	sum_beat_t expected_sums[$];
	int        fails = 0;
	int        send_idle = 0, recv_idle = 0;
	bit        took = 1'b0;

	logic [6:0]      pulses_cfg = 7'd5;
	logic [10:0]     rows_cfg = 11'd5, cols_cfg = 11'd64;
	npi_pkg::mode_t  layout = npi_pkg::MODE_ERR;
	int unsigned     row_pos = 0, col_pos = 0;
	logic [21:0]     acc_store [0:4095];

	function automatic int unsigned dim_of(logic [10:0] v);
		if (v == 0) return 1;
		if (v > 1024) return 1024;
		return v;
	endfunction

	function automatic void pick_layout();
		int unsigned p, r, c, need;
		p = pulses_cfg;
		r = dim_of(rows_cfg);
		c = dim_of(cols_cfg);
		layout = npi_pkg::MODE_ERR;
		need = 0;
		if (p != 0 && p <= 64) begin
			if (r == p) begin
				layout = npi_pkg::MODE_ROWS; need = c;
			end else if (c == p) begin
				layout = npi_pkg::MODE_COLS; need = 1;
			end else if (r % p == 0) begin
				layout = npi_pkg::MODE_RBLK; need = (r / p) * c;
			end else if (c % p == 0) begin
				layout = npi_pkg::MODE_CBLK; need = c / p;
			end
		end
		if (need > 4096) layout = npi_pkg::MODE_ERR;
	endfunction

	function automatic void set_reg(npi_pkg::reg_idx_t idx, logic [31:0] v);
		case (idx)
			npi_pkg::REG_PULSE: pulses_cfg = v[6:0];
			npi_pkg::REG_ROWS:  rows_cfg = v[10:0];
			npi_pkg::REG_COLS:  cols_cfg = v[10:0];
			default: return;
		endcase
		row_pos = 0;
		col_pos = 0;
		pick_layout();
	endfunction

	function automatic int unsigned int_magnitude(logic signed [15:0] re,
			logic signed [15:0] im);
		longint unsigned x, res, b, a1, a2;
		a1 = (re < 0) ? -longint'(re) : longint'(re);
		a2 = (im < 0) ? -longint'(im) : longint'(im);
		x = a1 * a1 + a2 * a2;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return 32'(res);
	endfunction

	function automatic void integrate_sample(sample_t s);
		int unsigned rows, cols, p, r, c, pulse, orow, ocol, idx, tot;
		bit last;
		sum_beat_t e;
		rows = dim_of(rows_cfg);
		cols = dim_of(cols_cfg);
		p = pulses_cfg;
		r = row_pos;
		c = col_pos;
		last = (r + 1 >= rows) && (c + 1 >= cols);
		if (c + 1 >= cols) begin
			col_pos = 0;
			row_pos = (r + 1 >= rows) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
		if (layout == npi_pkg::MODE_ERR) begin
			if (last) begin
				e = '0;
				e.last = 1'b1;
				e.status = 1'b1;
				expected_sums.push_back(e);
			end
			return;
		end
		case (layout)
			npi_pkg::MODE_ROWS: begin
				pulse = r; orow = 0; ocol = c; idx = c;
			end
			npi_pkg::MODE_COLS: begin
				pulse = c; orow = r; ocol = 0; idx = 0;
			end
			npi_pkg::MODE_RBLK: begin
				pulse = r / (rows / p); orow = r % (rows / p); ocol = c;
				idx = orow * cols + c;
			end
			default: begin
				pulse = c / (cols / p); orow = r; ocol = c % (cols / p); idx = ocol;
			end
		endcase
		if (idx >= 4096) idx = 0;
		tot = int_magnitude(s.re, s.im);
		if (pulse != 0) tot += acc_store[idx];
		if (tot > npi_pkg::SUM_MAX) tot = npi_pkg::SUM_MAX;
		acc_store[idx] = 22'(tot);
		if (pulse + 1 == p) begin
			e.sum = 22'(tot);
			e.row = 10'(orow);
			e.col = 10'(ocol);
			e.last = last;
			e.status = 1'b0;
			expected_sums.push_back(e);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			integrate_sample('{sample_real, sample_imag});
			took = 1'b1;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_sums.size() == 0) begin
				$display("%0t unexpected beat: sum %0d row %0d col %0d last %0b status %0b",
					$time, mag_sum, out_row, out_col, last_of_matrix, status);
				fails++;
			end else begin
				sum_beat_t e;
				e = expected_sums.pop_front();
				if (e.sum !== mag_sum || e.row !== out_row || e.col !== out_col ||
						e.last !== last_of_matrix || e.status !== status) begin
					$display("%0t expected sum %0d row %0d col %0d last %0b status %0b",
						$time, e.sum, e.row, e.col, e.last, e.status);
					$display("%0t actual   sum %0d row %0d col %0d last %0b status %0b",
						$time, mag_sum, out_row, out_col, last_of_matrix, status);
					fails++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || took) begin
				took = 1'b0;
				if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle) begin
					sample_t s;
					s = pending_samples.pop_front();
					sample_real <= s.re;
					sample_imag <= s.im;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	function automatic sample_t any_sample();
		sample_t s;
		logic signed [15:0] ext [4] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
		case ($urandom_range(3))
			0: begin
				s.re = ext[$urandom_range(3)]; s.im = ext[$urandom_range(3)];
			end
			1: begin
				s.re = $signed(16'($urandom_range(511))) - 16'sd256;
				s.im = $signed(16'($urandom_range(511))) - 16'sd256;
			end
			default: begin
				s.re = 16'($urandom); s.im = 16'($urandom);
			end
		endcase
		return s;
	endfunction

	task automatic drain();
		wait (pending_samples.size() == 0 && !in_valid && expected_sums.size() == 0);
		repeat (40) @(negedge clk);
	endtask

	task automatic reg_write(npi_pkg::reg_idx_t idx, logic [31:0] v);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = 4'(idx) << 2; pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		set_reg(idx, v);
	endtask

	task automatic load_geometry(int p, int r, int c);
		drain();
		reg_write(npi_pkg::REG_PULSE, p);
		reg_write(npi_pkg::REG_ROWS, r);
		reg_write(npi_pkg::REG_COLS, c);
	endtask

	task automatic queue_samples(int n);
		repeat (n) pending_samples.push_back(any_sample());
	endtask

	initial begin
		sample_t d;
		int total, n, k, geo;
		int geos [12][3] = '{'{2, 2, 4}, '{4, 3, 4}, '{2, 6, 3}, '{3, 2, 6},
			'{1, 1, 7}, '{1, 3, 1}, '{3, 9, 2}, '{4, 5, 8}, '{5, 5, 3},
			'{2, 4, 0}, '{1, 0, 3}, '{6, 1, 6}};
		pick_layout();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle = 23; recv_idle = 56;
		for (int i = 0; i < 16; i++) begin
			d.re = i[0] ? 16'sh7fff : 16'sh8000;
			d.im = i[1] ? 16'sh7fff : (i[2] ? 16'sh0000 : 16'sh8000);
			if (i[3]) d.re = 16'sh0000;
			pending_samples.push_back(d);
		end
		for (int b = 0; b < 16; b++) begin
			d.re = 16'sh0001 << b; d.im = ~(16'sh0001 << b);
			pending_samples.push_back(d);
		end
		queue_samples(5 * 64 - 32);

		load_geometry(64, 64, 2);
		queue_samples(128);
		load_geometry(1, 1, 1024);
		queue_samples(96);
		load_geometry(1, 2047, 1);
		queue_samples(96);
		load_geometry(0, 1, 2);
		queue_samples(4);
		load_geometry(127, 2, 3);
		queue_samples(6);
		load_geometry(4, 3, 5);
		queue_samples(15);
		load_geometry(1, 5, 1000);
		queue_samples(40);
		load_geometry(2, 2, 4);
		queue_samples(3);
		drain();
		reg_write(npi_pkg::REG_COLS, 3);
		queue_samples(12);

		total = 0;
		while (total < 550) begin
			if (total >= 180) begin
				send_idle = 56; recv_idle = 23;
			end
			if (total >= 370) begin
				send_idle = 0; recv_idle = 0;
			end
			geo = $urandom_range(11);
			load_geometry(geos[geo][0], geos[geo][1], geos[geo][2]);
			n = dim_of(11'(geos[geo][1])) * dim_of(11'(geos[geo][2]));
			k = $urandom_range(1, 4);
			if ($urandom_range(4) == 0) begin
				queue_samples(n * (k - 1) + $urandom_range(1, n));
				total += n * (k - 1) + 1;
			end else begin
				queue_samples(n * k);
				total += n * k;
			end
		end
		drain();
		if (fails == 0)
			$display("noncoherent_pulse_integrator_unit: match");
		else
			$display("noncoherent_pulse_integrator_unit: mismatch");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("noncoherent_pulse_integrator_unit: mismatch");
		$finish;
	end
endmodule
